// ----- rtl/cpd_pkg.sv -----
// Package with the types, constants and codes of the command packet deframer.
package cpd_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65536;
  localparam int unsigned IDX_W = $clog2(MAX_PACKET_BYTES + 1);

  localparam int unsigned HDR_FIRST  = 4;
  localparam int unsigned HDR_LAST   = 27;
  localparam int unsigned FIXED_PART = 32;
  localparam int unsigned TINY_LIMIT = 9;

  // Header bytes HDR_FIRST up to the one before HDR_LAST are held in a shift line.
  localparam int unsigned HDR_HOLD_BITS = (HDR_LAST - HDR_FIRST) * 8;
  localparam int unsigned HDR_ALL_BITS  = HDR_HOLD_BITS + 8;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PARAM  = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TINY     = 2'd1,
    ST_SHORT    = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] target_id;
    logic [31:0] source_id;
    logic [7:0]  version_code;
    logic [7:0]  param_kind;
    logic [31:0] command_id;
    logic [31:0] tag_word;
    logic [31:0] param_length;
    logic [7:0]  param_byte;
    logic [31:0] crc_word;
    status_t     status;
    logic        packet_end;
  } out_item_t;

endpackage

// ----- rtl/cpd_out_buf.sv -----
// Output register with a skid stage for the deframer result channel.
module cpd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cpd_pkg::out_item_t  push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output cpd_pkg::out_item_t  out_data
);
  import cpd_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      slot_free;

  // The output slot can take new data when empty or being drained this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (slot_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/command_packet_deframer_core.sv -----
// Command packet deframer: splits a byte stream into header, parameter and end requests.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one packet byte per request,
//   with last_byte set on the final byte of a packet. Bytes 0..3 are skipped, bytes
//   4..27 form the header, which is reported as one request when byte 27 arrives.
//   Later bytes up to the declared parameter length are passed out one per request
//   unless the parameter type equals the none code. The final byte always yields an
//   end request with the last four bytes as the CRC word and a status.
//   The none code is written via cfg_wr_en / cfg_wr_data; the user must write it only while idle (unchecked).
// Timing:
//   One byte is accepted per cycle while in_stall is low. Each result is registered in
//   the output stage, or the skid stage while out_stall holds it; per-byte work is compares and shifts.
// Reset:
//   Synchronous, active low. Clears the packet state (not the header shift line), the output
//   stage and sets the none code to zero.
// Back pressure:
//   While out_stall holds a result, one further result is kept in a skid stage;
//   in_stall rises only once that stage is occupied.
module command_packet_deframer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cpd_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);
  import cpd_pkg::*;

  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [HDR_HOLD_BITS-1:0] hdr_r, hdr_nxt;
  logic [31:0]              decl_len_r, decl_len_nxt;
  logic                     type_none_r, type_none_nxt;
  logic [31:0]              tail_r, tail_nxt;
  logic [7:0]               none_code_r;

  logic                     accept;
  logic                     overflow;
  logic                     buf_full;
  logic [HDR_ALL_BITS-1:0]  hdr_all;
  logic [IDX_W-1:0]         idx_off;
  logic [IDX_W-1:0]         total;
  logic                     res_valid;
  out_item_t                res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = buf_full;
  assign overflow = idx_r >= IDX_W'(MAX_PACKET_BYTES);
  assign hdr_all  = {hdr_r, in_data.data_byte};
  assign idx_off  = idx_r - IDX_W'(HDR_LAST + 1);
  assign total    = idx_r + IDX_W'(1);

  // Result formation for the byte on the input port.
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (in_data.last_byte) begin
      res_valid       = 1'b1;
      res.kind        = KIND_END;
      res.crc_word    = {tail_r[23:0], in_data.data_byte};
      res.packet_end  = 1'b1;
      if (!overflow && total <= IDX_W'(TINY_LIMIT)) begin
        res.status = ST_TINY;
      end else if (!overflow && total < IDX_W'(FIXED_PART)) begin
        res.status = ST_SHORT;
      end else if (overflow ||
                   (33'(total) != 33'(decl_len_r) + 33'(FIXED_PART))) begin
        res.status = ST_MISMATCH;
      end else begin
        res.status = ST_OK;
      end
    end else if (idx_r == IDX_W'(HDR_LAST)) begin
      res_valid        = 1'b1;
      res.kind         = KIND_HEADER;
      res.target_id    = hdr_all[191:160];
      res.source_id    = hdr_all[159:128];
      res.version_code = hdr_all[127:120];
      res.param_kind   = hdr_all[119:112];
      res.command_id   = hdr_all[95:64];
      res.tag_word     = hdr_all[63:32];
      res.param_length = hdr_all[31:0];
    end else if (!overflow && idx_r > IDX_W'(HDR_LAST) && !type_none_r &&
                 32'(idx_off) < decl_len_r) begin
      res_valid      = 1'b1;
      res.kind       = KIND_PARAM;
      res.param_byte = in_data.data_byte;
    end
  end

  // Packet state update.
  always_comb begin
    idx_nxt       = idx_r;
    hdr_nxt       = hdr_r;
    decl_len_nxt  = decl_len_r;
    type_none_nxt = type_none_r;
    tail_nxt      = tail_r;
    if (accept) begin
      if (in_data.last_byte) begin
        idx_nxt       = '0;
        decl_len_nxt  = '0;
        type_none_nxt = 1'b0;
        tail_nxt      = '0;
      end else begin
        tail_nxt = {tail_r[23:0], in_data.data_byte};
        if (!overflow) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
        if (idx_r >= IDX_W'(HDR_FIRST) && idx_r < IDX_W'(HDR_LAST)) begin
          hdr_nxt = {hdr_r[HDR_HOLD_BITS-9:0], in_data.data_byte};
        end
        if (idx_r == IDX_W'(HDR_LAST)) begin
          decl_len_nxt  = hdr_all[31:0];
          type_none_nxt = hdr_all[119:112] == none_code_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      decl_len_r  <= '0;
      type_none_r <= 1'b0;
      tail_r      <= '0;
      none_code_r <= '0;
    end else begin
      idx_r       <= idx_nxt;
      decl_len_r  <= decl_len_nxt;
      type_none_r <= type_none_nxt;
      tail_r      <= tail_nxt;
      if (cfg_wr_en) begin
        none_code_r <= cfg_wr_data;
      end
    end
    hdr_r <= hdr_nxt;
  end

  cpd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    buf_full |-> out_valid)
    else $error("skid stage holds a request while the output stage is empty");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_W'(MAX_PACKET_BYTES))
    else $error("byte index ran past its saturation point");

  a_header_at_27: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res_valid && res.kind == KIND_HEADER) |-> idx_r == IDX_W'(HDR_LAST))
    else $error("header request produced at the wrong byte position");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_byte) |=> (idx_r == '0 && tail_r == '0))
    else $error("packet state not cleared after the final byte");
`endif

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the command packet deframer core.
module tb;
  import cpd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;

  command_packet_deframer_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("Some tests failed");
    $finish;
  end

  in_item_t    pending_bytes[$];
  out_item_t   expected_reqs[$];
  logic [7:0]  frame_bytes[$];
  int unsigned queued_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned errors = 0;
  bit          in_taken = 1'b0;
  bit          calm = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;

  // Shadow copy of the deframer state.
  logic [7:0]  none_code = '0;
  int unsigned rx_count = 0;
  logic [7:0]  hdr_bytes [HDR_FIRST:HDR_LAST];
  logic [31:0] rx_param_len = '0;
  bit          rx_no_params = 1'b0;
  logic [31:0] rx_tail = '0;

  task automatic clear_packet();
    rx_count = 0;
    foreach (hdr_bytes[i]) hdr_bytes[i] = '0;
    rx_param_len = '0;
    rx_no_params = 1'b0;
    rx_tail = '0;
  endtask

  // Works out the request, if any, that one accepted byte produces.
  task automatic deframe_byte(input in_item_t item, output bit produced, output out_item_t req);
    int unsigned idx;
    bit          ovf;
    longint unsigned total;
    logic [7:0]  b;
    idx = rx_count;
    ovf = idx >= MAX_PACKET_BYTES;
    b = item.data_byte;
    req = '0;
    produced = 1'b0;
    rx_tail = {rx_tail[23:0], b};
    if (!ovf && idx >= HDR_FIRST && idx <= HDR_LAST) hdr_bytes[idx] = b;
    if (item.last_byte) begin
      total = longint'(idx) + 1;
      req.kind = KIND_END;
      req.crc_word = rx_tail;
      req.packet_end = 1'b1;
      if (!ovf && total <= TINY_LIMIT) req.status = ST_TINY;
      else if (!ovf && total < FIXED_PART) req.status = ST_SHORT;
      else if (ovf || total != longint'(FIXED_PART) + longint'(rx_param_len))
        req.status = ST_MISMATCH;
      else req.status = ST_OK;
      produced = 1'b1;
      clear_packet();
      return;
    end
    if (!ovf && idx == HDR_LAST) begin
      rx_param_len = {hdr_bytes[24], hdr_bytes[25], hdr_bytes[26], hdr_bytes[27]};
      rx_no_params = hdr_bytes[13] == none_code;
      req.kind = KIND_HEADER;
      req.target_id = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], hdr_bytes[7]};
      req.source_id = {hdr_bytes[8], hdr_bytes[9], hdr_bytes[10], hdr_bytes[11]};
      req.version_code = hdr_bytes[12];
      req.param_kind = hdr_bytes[13];
      req.command_id = {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]};
      req.tag_word = {hdr_bytes[20], hdr_bytes[21], hdr_bytes[22], hdr_bytes[23]};
      req.param_length = rx_param_len;
      produced = 1'b1;
    end else if (!ovf && idx > HDR_LAST && !rx_no_params &&
                 longint'(idx - HDR_LAST - 1) < longint'(rx_param_len)) begin
      req.kind = KIND_PARAM;
      req.param_byte = b;
      produced = 1'b1;
    end
    if (!ovf) rx_count = idx + 1;
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH at request %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  function automatic int pick_idle();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Driver: a new byte goes out once the previous one was taken.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_bytes.pop_front();
        send_gap = pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_idle();
    end
  end

  // Monitor: predicts on accepted bytes and checks accepted requests.
  always @(posedge clk) begin
    bit        produced;
    out_item_t req;
    out_item_t want;
    in_taken = rst_n && in_valid && !in_stall;
    if (in_taken) begin
      accepted_cnt++;
      deframe_byte(in_data, produced, req);
      if (produced) expected_reqs.push_back(req);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reqs.size() == 0) begin
        report_mismatch("request with nothing expected");
      end else begin
        want = expected_reqs.pop_front();
        check_field("kind", out_data.kind, want.kind);
        check_field("target_id", out_data.target_id, want.target_id);
        check_field("source_id", out_data.source_id, want.source_id);
        check_field("version_code", out_data.version_code, want.version_code);
        check_field("param_kind", out_data.param_kind, want.param_kind);
        check_field("command_id", out_data.command_id, want.command_id);
        check_field("tag_word", out_data.tag_word, want.tag_word);
        check_field("param_length", out_data.param_length, want.param_length);
        check_field("param_byte", out_data.param_byte, want.param_byte);
        check_field("crc_word", out_data.crc_word, want.crc_word);
        check_field("status", out_data.status, want.status);
        check_field("packet_end", out_data.packet_end, want.packet_end);
      end
      results_seen++;
    end
  end

  task automatic put_word(input logic [31:0] w);
    frame_bytes.push_back(w[31:24]);
    frame_bytes.push_back(w[23:16]);
    frame_bytes.push_back(w[15:8]);
    frame_bytes.push_back(w[7:0]);
  endtask

  task automatic build_frame(input logic [31:0] plen, input logic [7:0] ptype,
                             input int nparams);
    frame_bytes = {};
    put_word($urandom());
    put_word($urandom());
    put_word($urandom());
    frame_bytes.push_back(8'($urandom()));
    frame_bytes.push_back(ptype);
    frame_bytes.push_back(8'($urandom()));
    frame_bytes.push_back(8'($urandom()));
    put_word($urandom());
    put_word($urandom());
    put_word(plen);
    for (int i = 0; i < nparams; i++) frame_bytes.push_back(8'($urandom()));
    put_word($urandom());
  endtask

  task automatic emit(input int first, input int upto, input bit close);
    in_item_t item;
    for (int i = first; i < upto; i++) begin
      item.data_byte = frame_bytes[i];
      item.last_byte = close && (i == upto - 1);
      pending_bytes.push_back(item);
      queued_cnt++;
    end
  endtask

  task automatic noise_frame(input int n);
    frame_bytes = {};
    for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom()));
    emit(0, n, 1'b1);
  endtask

  task automatic add_random_packet();
    int          r;
    int          n;
    int          cut;
    logic [7:0]  ptype;
    logic [31:0] plen;
    r = $urandom_range(0, 99);
    ptype = ($urandom_range(0, 99) < 30) ? none_code : 8'($urandom());
    if (r < 60) begin
      n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12) : $urandom_range(13, 40);
      build_frame(n, ptype, n);
      emit(0, frame_bytes.size(), 1'b1);
    end else if (r < 75) begin
      build_frame($urandom_range(0, 8), ptype, $urandom_range(0, 8));
      case ($urandom_range(0, 7))
        0: cut = 1;
        1: cut = 2;
        2: cut = 9;
        3: cut = 10;
        4: cut = 27;
        5: cut = 28;
        6: cut = 31;
        default: cut = $urandom_range(1, frame_bytes.size());
      endcase
      emit(0, cut, 1'b1);
    end else if (r < 90) begin
      plen = ($urandom_range(0, 1) == 1) ? $urandom() : 32'($urandom_range(0, 12));
      build_frame(plen, ptype, $urandom_range(0, 12));
      emit(0, frame_bytes.size(), 1'b1);
    end else begin
      noise_frame($urandom_range(1, 60));
    end
  endtask

  // All queued bytes taken and every expected request delivered.
  task automatic wait_idle();
    while (!(accepted_cnt == queued_cnt && expected_reqs.size() == 0)) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_none_code(input logic [7:0] code);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= code;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    none_code = code;
  endtask

  initial begin
    int unsigned phase_start;
    logic [7:0]  new_code;
    int          held;
    clear_packet();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Tiny and short packets around the status boundaries.
    noise_frame(1);
    noise_frame(3);
    noise_frame(9);
    noise_frame(10);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      calm = (p % 3) == 2;
      case (p)
        0: ;
        1: set_none_code(8'hFF);
        2: set_none_code(8'h00);
        3: begin
          // The code changes while a packet is half way through its header.
          new_code = 8'($urandom());
          build_frame(5, new_code, 5);
          held = $urandom_range(5, 26);
          emit(0, held, 1'b0);
          wait_idle();
          set_none_code(new_code);
          emit(held, frame_bytes.size(), 1'b1);
        end
        default: set_none_code(8'($urandom()));
      endcase
      phase_start = queued_cnt;
      while (queued_cnt - phase_start < 85) add_random_packet();
      wait_idle();
    end

    calm = 1'b0;
    add_random_packet();
    wait_idle();
    repeat (10) @(negedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
